>>> hdl/mts_pkg.sv
// Package for the minimum-tracking stack: payload structs, operation and status codes,
// controller state encoding and the command and status structs between controller and datapath.
// Depends on nothing; every other file of the block imports it.
package mts_pkg;

   // Fixed field widths of the payload.
   localparam int VALUE_W = 32;
   localparam int CNT_W   = 7;

   // Value reported for top and minimum when the stack is empty.
   localparam logic signed [VALUE_W-1:0] INT_MIN = {1'b1, {(VALUE_W-1){1'b0}}};

   // Capacity register value after reset.
   localparam logic [CNT_W-1:0] CAP_RESET = 7'd64;

   typedef enum logic [1:0] {
      OP_PUSH  = 2'd0,
      OP_POP   = 2'd1,
      OP_QUERY = 2'd2
   } op_type;

   typedef enum logic [1:0] {
      STATUS_OK        = 2'd0,
      STATUS_OVERFLOW  = 2'd1,
      STATUS_UNDERFLOW = 2'd2
   } status_type;

   typedef enum logic {
      ST_IDLE,
      ST_FETCH
   } state_type;

   typedef struct packed {
      logic [1:0]                operation;
      logic signed [VALUE_W-1:0] push_value;
   } req_payload_type;

   typedef struct packed {
      logic signed [VALUE_W-1:0] top_value;
      logic signed [VALUE_W-1:0] minimum_value;
      logic [CNT_W-1:0]          entry_count;
      logic                      empty_flag;
      logic                      full_flag;
      status_type                status;
   } rsp_payload_type;

   // Commands from the controller to the datapath.
   typedef struct packed {
      logic       push_en;
      logic       pop_en;
      logic       fetch_top;
      logic       rsp_load;
      status_type status;
   } ctl_cmd_type;

   // Stack condition reported by the datapath before the step.
   typedef struct packed {
      logic empty;
      logic full;
      logic single;
   } dp_status_type;

endpackage

>>> hdl/min_tracking_stack.sv
// Minimum-tracking stack of signed 32-bit values.
// Request channel (req_valid, req_ready, req_payload): each beat is a push, a pop or a query;
// code 3 acts as a query. Response channel (rsp_valid, rsp_ready, rsp_payload): exactly one
// beat per request, giving top value, minimum, count, empty and full flags and a status.
// Push and query results are registered at the accepting edge. A pop that leaves entries
// behind reads the new top from the entry memory's single read port and answers from the
// fetch state after that read, taking no new request meanwhile; all other items answer
// at the accepting edge. An overflowing push or an underflowing pop reports its status and
// changes nothing. The csr_ port writes the usable capacity (reset 64, clamped to
// one..MAX_DEPTH); the user must write it only while the block is idle (not enforced).
// A response that is not taken holds its beat; a new request is taken in the same cycle
// the waiting response leaves, otherwise req_ready stays low.
// Reset clears the count and the response flag and restores the capacity; memory contents
// are not cleared. MAX_DEPTH ranges from 2 to 127.
// Depends on mts_pkg, mts_controller and mts_datapath.
module min_tracking_stack #(
   parameter int MAX_DEPTH = 64
) (
   input  logic                      clock,
   input  logic                      reset,
   input  logic                      req_valid,
   output logic                      req_ready,
   input  mts_pkg::req_payload_type  req_payload,
   output logic                      rsp_valid,
   input  logic                      rsp_ready,
   output mts_pkg::rsp_payload_type  rsp_payload,
   input  logic                      csr_write_enable,
   input  logic [mts_pkg::CNT_W-1:0] csr_write_data
);
   import mts_pkg::*;

   ctl_cmd_type   cmd;
   dp_status_type dp_status;

   // Sequencing of request and response beats.
   mts_controller u_ctl (
      .clock     (clock),
      .reset     (reset),
      .req_valid (req_valid),
      .req_ready (req_ready),
      .operation (req_payload.operation),
      .rsp_valid (rsp_valid),
      .rsp_ready (rsp_ready),
      .dp_status (dp_status),
      .cmd       (cmd)
   );

   // Storage and result formation.
   mts_datapath #(
      .MAX_DEPTH (MAX_DEPTH)
   ) u_dp (
      .clock            (clock),
      .reset            (reset),
      .req_payload      (req_payload),
      .csr_write_enable (csr_write_enable),
      .csr_write_data   (csr_write_data),
      .cmd              (cmd),
      .dp_status        (dp_status),
      .rsp_payload      (rsp_payload)
   );

endmodule

>>> hdl/mts_controller.sv
// Controller of the minimum-tracking stack: decodes each request beat, sequences the
// memory fetch after a pop and owns the response valid flag.
// Depends on mts_pkg.
module mts_controller (
   input  logic                     clock,
   input  logic                     reset,
   input  logic                     req_valid,
   output logic                     req_ready,
   input  logic [1:0]               operation,
   output logic                     rsp_valid,
   input  logic                     rsp_ready,
   input  mts_pkg::dp_status_type   dp_status,
   output mts_pkg::ctl_cmd_type     cmd
);
   import mts_pkg::*;

   state_type state_ff;
   state_type state_in;
   logic      rsp_valid_ff;
   logic      rsp_valid_in;
   logic      accept;

   // A new beat is taken only in idle and when the response slot is free or emptying.
   assign req_ready = (state_ff == ST_IDLE) && (!rsp_valid_ff || rsp_ready);
   assign accept    = req_valid && req_ready;
   assign rsp_valid = rsp_valid_ff;

   // Next state: a pop that leaves entries behind must wait for the new top from memory.
   always_comb begin
      state_in = state_ff;
      case (state_ff)
         ST_IDLE: begin
            if (accept && operation == OP_POP && !dp_status.empty && !dp_status.single) begin
               state_in = ST_FETCH;
            end
         end
         ST_FETCH: begin
            state_in = ST_IDLE;
         end
         default: begin
            state_in = ST_IDLE;
         end
      endcase
   end

   // Command outputs for the datapath.
   always_comb begin
      cmd = '0;
      cmd.status = STATUS_OK;
      case (state_ff)
         ST_IDLE: begin
            case (operation)
               OP_PUSH: begin
                  if (dp_status.full) begin
                     cmd.status = STATUS_OVERFLOW;
                  end else begin
                     cmd.push_en = accept;
                  end
                  cmd.rsp_load = accept;
               end
               OP_POP: begin
                  if (dp_status.empty) begin
                     cmd.status   = STATUS_UNDERFLOW;
                     cmd.rsp_load = accept;
                  end else begin
                     cmd.pop_en   = accept;
                     cmd.rsp_load = accept && dp_status.single;
                  end
               end
               default: begin
                  cmd.rsp_load = accept;
               end
            endcase
         end
         ST_FETCH: begin
            cmd.fetch_top = 1'b1;
            cmd.rsp_load  = 1'b1;
         end
         default: begin
            cmd = '0;
         end
      endcase
   end

   // The response flag is set when a result is loaded and cleared when it is taken.
   always_comb begin
      if (cmd.rsp_load) begin
         rsp_valid_in = 1'b1;
      end else if (rsp_ready) begin
         rsp_valid_in = 1'b0;
      end else begin
         rsp_valid_in = rsp_valid_ff;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= ST_IDLE;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   // The fetch state is entered only straight after an accepted pop.
   assert property (@(posedge clock) disable iff (reset)
      (state_ff == ST_FETCH) |-> $past(cmd.pop_en))
      else $error("fetch state without a preceding pop");

   // A result is never loaded over one that is still waiting.
   assert property (@(posedge clock) disable iff (reset)
      cmd.rsp_load |-> (!rsp_valid_ff || rsp_ready))
      else $error("response overwritten before it was taken");

   // A pending pop fetch holds off new request beats.
   assert property (@(posedge clock) disable iff (reset)
      (state_ff == ST_FETCH) |-> !req_ready)
      else $error("request taken during top fetch");

endmodule

>>> hdl/mts_datapath.sv
// Datapath of the minimum-tracking stack: entry memory, cached top value and minimum,
// entry count, capacity register and the response register.
// Depends on mts_pkg.
module mts_datapath #(
   parameter int MAX_DEPTH = 64
) (
   input  logic                      clock,
   input  logic                      reset,
   input  mts_pkg::req_payload_type  req_payload,
   input  logic                      csr_write_enable,
   input  logic [mts_pkg::CNT_W-1:0] csr_write_data,
   input  mts_pkg::ctl_cmd_type      cmd,
   output mts_pkg::dp_status_type    dp_status,
   output mts_pkg::rsp_payload_type  rsp_payload
);
   import mts_pkg::*;

   localparam int               AW      = $clog2(MAX_DEPTH);
   localparam logic [CNT_W-1:0] MAX_CNT = CNT_W'(MAX_DEPTH);

   // Each memory word holds a value and the minimum of it and everything below it.
   logic [2*VALUE_W-1:0]      stack_mem [MAX_DEPTH];
   logic [2*VALUE_W-1:0]      rd_ff;
   logic [CNT_W-1:0]          count_ff;
   logic [CNT_W-1:0]          count_in;
   logic [CNT_W-1:0]          cap_ff;
   logic [CNT_W-1:0]          cap_eff;
   logic [CNT_W-1:0]          below_idx;
   logic signed [VALUE_W-1:0] top_val_ff;
   logic signed [VALUE_W-1:0] top_val_in;
   logic signed [VALUE_W-1:0] top_min_ff;
   logic signed [VALUE_W-1:0] top_min_in;
   logic signed [VALUE_W-1:0] push_min;
   rsp_payload_type           rsp_ff;
   rsp_payload_type           rsp_in;

   // Capacity clamped to the range one to the memory depth.
   always_comb begin
      if (cap_ff == '0) begin
         cap_eff = CNT_W'(1);
      end else if (cap_ff > MAX_CNT) begin
         cap_eff = MAX_CNT;
      end else begin
         cap_eff = cap_ff;
      end
   end

   assign dp_status.empty  = (count_ff == '0);
   assign dp_status.full   = (count_ff >= cap_eff);
   assign dp_status.single = (count_ff == CNT_W'(1));

   // Running minimum for a pushed value.
   assign push_min = (count_ff != '0 && top_min_ff < req_payload.push_value) ?
                     top_min_ff : req_payload.push_value;

   // Address of the entry that becomes the top after a pop.
   assign below_idx = count_ff - CNT_W'(2);

   // Next count and cached top.
   always_comb begin
      count_in   = count_ff;
      top_val_in = top_val_ff;
      top_min_in = top_min_ff;
      if (cmd.push_en) begin
         count_in   = count_ff + CNT_W'(1);
         top_val_in = req_payload.push_value;
         top_min_in = push_min;
      end else if (cmd.pop_en) begin
         count_in = count_ff - CNT_W'(1);
      end else if (cmd.fetch_top) begin
         top_val_in = rd_ff[2*VALUE_W-1:VALUE_W];
         top_min_in = rd_ff[VALUE_W-1:0];
      end
   end

   // Result beat describing the stack after the step.
   always_comb begin
      rsp_in.entry_count = count_in;
      rsp_in.empty_flag  = (count_in == '0);
      rsp_in.full_flag   = (count_in >= cap_eff);
      rsp_in.status      = cmd.status;
      if (count_in == '0) begin
         rsp_in.top_value     = INT_MIN;
         rsp_in.minimum_value = INT_MIN;
      end else begin
         rsp_in.top_value     = top_val_in;
         rsp_in.minimum_value = top_min_in;
      end
   end

   // Entry memory: written on push, read on pop.
   always_ff @(posedge clock) begin
      if (cmd.push_en) begin
         stack_mem[count_ff[AW-1:0]] <= {req_payload.push_value, push_min};
      end
      if (cmd.pop_en) begin
         rd_ff <= stack_mem[below_idx[AW-1:0]];
      end
   end

   // Control registers.
   always_ff @(posedge clock) begin
      if (reset) begin
         count_ff <= '0;
         cap_ff   <= CAP_RESET;
      end else begin
         count_ff <= count_in;
         if (csr_write_enable) begin
            cap_ff <= csr_write_data;
         end
      end
   end

   // Payload registers.
   always_ff @(posedge clock) begin
      top_val_ff <= top_val_in;
      top_min_ff <= top_min_in;
      if (cmd.rsp_load) begin
         rsp_ff <= rsp_in;
      end
   end

   assign rsp_payload = rsp_ff;

   // The count never passes the memory depth.
   assert property (@(posedge clock) disable iff (reset) count_ff <= MAX_CNT)
      else $error("entry count beyond memory depth");

   // A push is never issued on a full stack, nor a pop on an empty one.
   assert property (@(posedge clock) disable iff (reset)
      cmd.push_en |-> !dp_status.full)
      else $error("push issued on a full stack");

   assert property (@(posedge clock) disable iff (reset)
      cmd.pop_en |-> !dp_status.empty)
      else $error("pop issued on an empty stack");

endmodule

>>> verif/min_stack_checker.sv
// Checker for the minimum-tracking stack: watches the request, response and capacity ports,
// keeps its own copy of the stack and compares every response beat field by field.
// Depends on mts_pkg for the payload structs and the operation and status codes.
module min_stack_checker #(
   parameter int MAX_DEPTH = 64
) (
   input  logic                      clock,
   input  logic                      reset,
   input  logic                      req_valid,
   input  logic                      req_ready,
   input  mts_pkg::req_payload_type  req_payload,
   input  logic                      rsp_valid,
   input  logic                      rsp_ready,
   input  mts_pkg::rsp_payload_type  rsp_payload,
   input  logic                      csr_write_enable,
   input  logic [mts_pkg::CNT_W-1:0] csr_write_data,
   output int                        error_count,
   output int                        pending_count,
   output int                        request_count,
   output int                        overflow_count,
   output int                        underflow_count,
   output int                        deepest_count
);
   import mts_pkg::*;

   // Mismatch lines beyond this number are counted but not printed.
   localparam int PRINT_LIMIT = 100;

   // Shadow copy of the stack and of the capacity register.
   logic signed [VALUE_W-1:0] value_mem [MAX_DEPTH];
   logic signed [VALUE_W-1:0] floor_mem [MAX_DEPTH];
   int unsigned               depth;
   logic [CNT_W-1:0]          capacity_reg;

   // Responses still owed by the block, oldest first.
   rsp_payload_type           owed_views [$];

   int errors;
   int requests;
   int overflows;
   int underflows;
   int deepest;

   // The capacity actually applied: zero acts as one, anything above the depth as the depth.
   function automatic int unsigned usable_capacity();
      if (capacity_reg == '0)
         return 1;
      if (capacity_reg > MAX_DEPTH)
         return MAX_DEPTH;
      return capacity_reg;
   endfunction

   // Applies one request to the shadow stack and returns the view the block should report.
   function automatic rsp_payload_type stack_view_after(input req_payload_type rq);
      rsp_payload_type           view;
      int unsigned               cap;
      logic signed [VALUE_W-1:0] floor_value;
      cap         = usable_capacity();
      view.status = STATUS_OK;
      case (rq.operation)
         OP_PUSH: begin
            if (depth >= cap) begin
               view.status = STATUS_OVERFLOW;
               overflows++;
            end else begin
               // The running minimum is carried up beside each value.
               floor_value = rq.push_value;
               if (depth > 0 && floor_mem[depth-1] < rq.push_value)
                  floor_value = floor_mem[depth-1];
               value_mem[depth] = rq.push_value;
               floor_mem[depth] = floor_value;
               depth++;
            end
         end
         OP_POP: begin
            if (depth == 0) begin
               view.status = STATUS_UNDERFLOW;
               underflows++;
            end else begin
               depth--;
            end
         end
         default: begin
            // Query, and the unused code that behaves as one, change nothing.
         end
      endcase
      if (depth > deepest)
         deepest = depth;

      // An empty stack reads as the most negative value.
      if (depth == 0) begin
         view.top_value     = INT_MIN;
         view.minimum_value = INT_MIN;
      end else begin
         view.top_value     = value_mem[depth-1];
         view.minimum_value = floor_mem[depth-1];
      end
      view.entry_count = depth[CNT_W-1:0];
      view.empty_flag  = (depth == 0);
      view.full_flag   = (depth >= cap);
      return view;
   endfunction

   task automatic check_field(input string field, input logic signed [63:0] want,
                              input logic signed [63:0] got);
      if (got !== want) begin
         errors++;
         if (errors <= PRINT_LIMIT)
            $display("%0t: %s mismatch, expected %0d, got %0d", $time, field, want, got);
      end
   endtask

   // Everything is sampled at the rising edge, before the block's outputs move.
   always @(posedge clock) begin : watch
      rsp_payload_type want;
      if (reset) begin
         depth        = 0;
         capacity_reg = CAP_RESET;
         owed_views.delete();
         errors       = 0;
         requests     = 0;
         overflows    = 0;
         underflows   = 0;
         deepest      = 0;
      end else begin
         if (csr_write_enable)
            capacity_reg = csr_write_data;

         // A response beat leaving now belongs to an earlier request.
         if (rsp_valid && rsp_ready) begin
            if (owed_views.size() == 0) begin
               errors++;
               $display("%0t: response beat with no request outstanding, got %p",
                        $time, rsp_payload);
            end else begin
               want = owed_views.pop_front();
               check_field("top_value", want.top_value, rsp_payload.top_value);
               check_field("minimum_value", want.minimum_value, rsp_payload.minimum_value);
               check_field("entry_count", want.entry_count, rsp_payload.entry_count);
               check_field("empty_flag", want.empty_flag, rsp_payload.empty_flag);
               check_field("full_flag", want.full_flag, rsp_payload.full_flag);
               check_field("status", want.status, rsp_payload.status);
            end
         end

         if (req_valid && req_ready) begin
            requests++;
            owed_views.push_back(stack_view_after(req_payload));
         end
      end

      error_count     <= errors;
      pending_count   <= owed_views.size();
      request_count   <= requests;
      overflow_count  <= overflows;
      underflow_count <= underflows;
      deepest_count   <= deepest;
   end

endmodule

>>> verif/testbench.sv
// Top of the minimum-tracking stack testbench: clock, reset, request and capacity stimulus,
// response back-pressure and the final verdict.
// Depends on mts_pkg, min_tracking_stack and min_stack_checker.
module testbench;
   import mts_pkg::*;

   localparam int PERIOD         = 4;
   localparam int TIMEOUT        = 2_000_000;
   localparam int PHASES         = 16;
   localparam int PHASE_ITEMS    = 97;
   localparam int HOLDOFF_CYCLES = 60;
   localparam int PRESSURE_PHASE = 4;

   // Operation code 3 has no name in the package; the block treats it as a query.
   localparam logic [1:0] OP_UNDEFINED = 2'd3;
   localparam logic signed [VALUE_W-1:0] INT_MAX = {1'b0, {(VALUE_W-1){1'b1}}};

   logic             clock;
   logic             reset;
   logic             req_valid;
   logic             req_ready;
   req_payload_type  req_payload;
   logic             rsp_valid;
   logic             rsp_ready;
   rsp_payload_type  rsp_payload;
   logic             csr_write_enable;
   logic [CNT_W-1:0] csr_write_data;

   int   idle_pct;
   int   stall_pct;
   logic holdoff_armed;
   logic holdoff;
   int   capacity_writes;

   int   error_count;
   int   pending_count;
   int   request_count;
   int   overflow_count;
   int   underflow_count;
   int   deepest_count;

   min_tracking_stack #(
      .MAX_DEPTH (64)
   ) uut (
      .clock            (clock),
      .reset            (reset),
      .req_valid        (req_valid),
      .req_ready        (req_ready),
      .req_payload      (req_payload),
      .rsp_valid        (rsp_valid),
      .rsp_ready        (rsp_ready),
      .rsp_payload      (rsp_payload),
      .csr_write_enable (csr_write_enable),
      .csr_write_data   (csr_write_data)
   );

   min_stack_checker #(
      .MAX_DEPTH (64)
   ) stack_check (
      .clock            (clock),
      .reset            (reset),
      .req_valid        (req_valid),
      .req_ready        (req_ready),
      .req_payload      (req_payload),
      .rsp_valid        (rsp_valid),
      .rsp_ready        (rsp_ready),
      .rsp_payload      (rsp_payload),
      .csr_write_enable (csr_write_enable),
      .csr_write_data   (csr_write_data),
      .error_count      (error_count),
      .pending_count    (pending_count),
      .request_count    (request_count),
      .overflow_count   (overflow_count),
      .underflow_count  (underflow_count),
      .deepest_count    (deepest_count)
   );

   initial clock = 1'b0;
   always #(PERIOD/2) clock = ~clock;

   // Hard stop in case the block hangs.
   initial begin
      #(TIMEOUT);
      $display("** min_tracking_stack: FAILED **");
      $finish;
   end

   // Long receiver hold-off, counted here once the stimulus arms it.
   initial begin
      holdoff = 1'b0;
      wait (holdoff_armed);
      @(posedge clock);
      holdoff <= 1'b1;
      repeat (HOLDOFF_CYCLES) @(posedge clock);
      holdoff <= 1'b0;
   end

   // Receiver back-pressure.
   always @(posedge clock) begin
      if (reset) begin
         rsp_ready <= 1'b0;
      end else begin
         rsp_ready <= !holdoff && ($urandom_range(99) >= stall_pct);
      end
   end

   // Offers one request beat, after an optional random gap, and waits for it to be taken.
   // Valid is only lowered inside a gap, so back-to-back beats keep it high.
   task automatic send_beat(input logic [1:0] op, input logic signed [VALUE_W-1:0] value);
      while ($urandom_range(99) < idle_pct) begin
         req_valid <= 1'b0;
         @(posedge clock);
      end
      req_valid   <= 1'b1;
      req_payload <= '{operation: op, push_value: value};
      do
         @(posedge clock);
      while (!(req_valid && req_ready));
   endtask

   // Stops offering and waits until every owed response has been taken.
   task automatic drain();
      req_valid <= 1'b0;
      @(posedge clock);
      while (pending_count != 0)
         @(posedge clock);
   endtask

   task automatic write_capacity(input logic [CNT_W-1:0] cap);
      csr_write_enable <= 1'b1;
      csr_write_data   <= cap;
      capacity_writes++;
      @(posedge clock);
      csr_write_enable <= 1'b0;
   endtask

   // Values lean on the extremes and on a narrow band, so that equal minimums occur often.
   function automatic logic signed [VALUE_W-1:0] pick_value();
      case ($urandom_range(9))
         0:       return INT_MIN;
         1:       return INT_MAX;
         2:       return $urandom_range(1) ? {VALUE_W{1'b0}} : {VALUE_W{1'b1}};
         3, 4, 5: return $signed($urandom_range(20)) - 10;
         default: return $urandom;
      endcase
   endfunction

   function automatic logic [CNT_W-1:0] pick_capacity(input int phase);
      case (phase % 8)
         0:       return CNT_W'(64);
         1:       return CNT_W'(1);
         2:       return CNT_W'($urandom_range(8, 2));
         3:       return CNT_W'(0);
         4:       return CNT_W'($urandom_range(64, 1));
         5:       return CNT_W'(127);
         6:       return CNT_W'($urandom_range(127, 65));
         default: return CNT_W'($urandom_range(20, 3));
      endcase
   endfunction

   initial begin : stimulus
      int         phase;
      int         n;
      int         r;
      int         push_pct;
      logic [1:0] op;

      reset            = 1'b1;
      req_valid        = 1'b0;
      req_payload      = '0;
      csr_write_enable = 1'b0;
      csr_write_data   = '0;
      idle_pct         = 0;
      stall_pct        = 0;
      holdoff_armed    = 1'b0;
      capacity_writes  = 0;

      repeat (4) @(posedge clock);
      reset <= 1'b0;
      @(posedge clock);

      // Directed: empty stack, extremes, overflow and underflow at a small capacity.
      write_capacity(CNT_W'(3));
      send_beat(OP_POP, '0);
      send_beat(OP_QUERY, '0);
      send_beat(OP_UNDEFINED, '0);
      send_beat(OP_PUSH, INT_MAX);
      send_beat(OP_PUSH, INT_MIN);
      send_beat(OP_PUSH, '0);
      send_beat(OP_PUSH, -1);
      send_beat(OP_UNDEFINED, INT_MAX);
      send_beat(OP_POP, '0);
      send_beat(OP_POP, '0);
      send_beat(OP_POP, '0);
      send_beat(OP_POP, '0);
      send_beat(OP_PUSH, 5);
      send_beat(OP_PUSH, 5);
      send_beat(OP_PUSH, 7);
      drain();

      // Capacity of zero acts as one, here below the entries already held.
      write_capacity(CNT_W'(0));
      send_beat(OP_PUSH, 1);
      send_beat(OP_QUERY, '0);
      send_beat(OP_POP, '0);
      send_beat(OP_POP, '0);
      send_beat(OP_POP, '0);
      send_beat(OP_PUSH, -3);
      send_beat(OP_PUSH, 4);
      drain();

      // Capacity beyond the depth acts as the full depth.
      write_capacity(CNT_W'(127));
      send_beat(OP_PUSH, -100);
      send_beat(OP_PUSH, 100);
      send_beat(OP_POP, '0);
      drain();

      // Random phases: each sets a capacity, an idling mode and a push bias.
      for (phase = 0; phase < PHASES; phase++) begin
         write_capacity(pick_capacity(phase));
         case (phase % 4)
            0: begin
               idle_pct  = 0;
               stall_pct <= 0;
            end
            1: begin
               idle_pct  = 65;
               stall_pct <= 0;
            end
            2: begin
               idle_pct  = 0;
               stall_pct <= 65;
            end
            default: begin
               idle_pct  = 20;
               stall_pct <= 20;
            end
         endcase
         case (phase % 3)
            0:       push_pct = 80;
            1:       push_pct = 50;
            default: push_pct = 25;
         endcase
         if (phase == PRESSURE_PHASE)
            holdoff_armed <= 1'b1;

         for (n = 0; n < PHASE_ITEMS; n++) begin
            r = $urandom_range(99);
            if (r < push_pct)
               op = OP_PUSH;
            else if (r < 90)
               op = OP_POP;
            else if (r < 96)
               op = OP_QUERY;
            else
               op = OP_UNDEFINED;
            send_beat(op, pick_value());
         end
         drain();
      end

      // Quiet cycles at the end to catch any stray response beat.
      stall_pct <= 0;
      repeat (20) @(posedge clock);

      $display("Run covered %0d requests over %0d capacity settings: %0d overflows, %0d underflows,",
               request_count, capacity_writes, overflow_count, underflow_count);
      $display("deepest stack %0d entries, with idling, stalls and a long receiver hold-off.",
               deepest_count);
      if (error_count == 0 && pending_count == 0)
         $display("** min_tracking_stack: PASSED **");
      else
         $display("** min_tracking_stack: FAILED **");
      $finish;
   end

endmodule

>>> filelist.f
hdl/mts_pkg.sv
hdl/mts_controller.sv
hdl/mts_datapath.sv
hdl/min_tracking_stack.sv
verif/min_stack_checker.sv
verif/testbench.sv
